/* rtl/mbsd_pkg.sv */
package mbsd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned PART_W     = WORD_W - BYTE_W;
    localparam int unsigned MNEM_W     = 6;
    localparam int unsigned REG_W      = 5;
    localparam int unsigned IMM_W      = 16;
    localparam int unsigned TARGET_W   = 26;
    localparam int unsigned OUT_BITS   = 2 * WORD_W + MNEM_W + 4 * REG_W + IMM_W + TARGET_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W  = OUT_TDATA_W - OUT_BITS;
    localparam logic [1:0]  LAST_BYTE_POS = 2'd3;

    typedef logic [5:0] field6_t;

    // Primary opcodes, bits 31..26
    localparam field6_t OP_SPECIAL = 6'd0;
    localparam field6_t OP_J       = 6'd2;
    localparam field6_t OP_JAL     = 6'd3;
    localparam field6_t OP_BEQ     = 6'd4;
    localparam field6_t OP_BNE     = 6'd5;
    localparam field6_t OP_ADDI    = 6'd8;
    localparam field6_t OP_ADDIU   = 6'd9;
    localparam field6_t OP_SLTI    = 6'd10;
    localparam field6_t OP_SLTIU   = 6'd11;
    localparam field6_t OP_ANDI    = 6'd12;
    localparam field6_t OP_ORI     = 6'd13;
    localparam field6_t OP_XORI    = 6'd14;
    localparam field6_t OP_LUI     = 6'd15;
    localparam field6_t OP_LB      = 6'd32;
    localparam field6_t OP_LH      = 6'd33;
    localparam field6_t OP_LW      = 6'd35;
    localparam field6_t OP_LBU     = 6'd36;
    localparam field6_t OP_LHU     = 6'd37;
    localparam field6_t OP_SB      = 6'd40;
    localparam field6_t OP_SH      = 6'd41;
    localparam field6_t OP_SW      = 6'd43;

    // Function field of SPECIAL, bits 5..0
    localparam field6_t FN_SLL     = 6'd0;
    localparam field6_t FN_SRL     = 6'd2;
    localparam field6_t FN_SRA     = 6'd3;
    localparam field6_t FN_SLLV    = 6'd4;
    localparam field6_t FN_SRLV    = 6'd6;
    localparam field6_t FN_SRAV    = 6'd7;
    localparam field6_t FN_JR      = 6'd8;
    localparam field6_t FN_JALR    = 6'd9;
    localparam field6_t FN_SYSCALL = 6'd12;
    localparam field6_t FN_MFHI    = 6'd16;
    localparam field6_t FN_MTHI    = 6'd17;
    localparam field6_t FN_MFLO    = 6'd18;
    localparam field6_t FN_MTLO    = 6'd19;
    localparam field6_t FN_MULT    = 6'd24;
    localparam field6_t FN_MULTU   = 6'd25;
    localparam field6_t FN_DIV     = 6'd26;
    localparam field6_t FN_DIVU    = 6'd27;
    localparam field6_t FN_ADD     = 6'd32;
    localparam field6_t FN_ADDU    = 6'd33;
    localparam field6_t FN_SUB     = 6'd34;
    localparam field6_t FN_SUBU    = 6'd35;
    localparam field6_t FN_AND     = 6'd36;
    localparam field6_t FN_OR      = 6'd37;
    localparam field6_t FN_XOR     = 6'd38;
    localparam field6_t FN_NOR     = 6'd39;
    localparam field6_t FN_SLT     = 6'd42;
    localparam field6_t FN_SLTU    = 6'd43;

    typedef enum logic [MNEM_W-1:0] {
        MN_ADD, MN_ADDU, MN_AND, MN_DIV, MN_DIVU, MN_JALR, MN_JR, MN_MFHI,
        MN_MFLO, MN_MTHI, MN_MTLO, MN_MULT, MN_MULTU, MN_NOR, MN_OR,
        MN_SLL, MN_SLLV, MN_SLT, MN_SLTU, MN_SRA, MN_SRAV, MN_SRL,
        MN_SRLV, MN_SUB, MN_SUBU, MN_SYSCALL, MN_XOR,
        MN_J, MN_JAL,
        MN_ADDI, MN_ADDIU, MN_ANDI, MN_BEQ, MN_BNE, MN_LB, MN_LBU,
        MN_LH, MN_LHU, MN_LUI, MN_LW, MN_ORI, MN_SB, MN_SLTI,
        MN_SLTIU, MN_SH, MN_SW, MN_XORI,
        MN_UNKNOWN
    } mnem_t;

    typedef struct packed {
        logic [WORD_W-1:0] number;
        logic [WORD_W-1:0] word;
    } word_item_t;

    function automatic mnem_t special_mnem(input field6_t fn);
        mnem_t mn;
        unique case (fn)
            FN_ADD:     mn = MN_ADD;
            FN_ADDU:    mn = MN_ADDU;
            FN_AND:     mn = MN_AND;
            FN_DIV:     mn = MN_DIV;
            FN_DIVU:    mn = MN_DIVU;
            FN_JALR:    mn = MN_JALR;
            FN_JR:      mn = MN_JR;
            FN_MFHI:    mn = MN_MFHI;
            FN_MFLO:    mn = MN_MFLO;
            FN_MTHI:    mn = MN_MTHI;
            FN_MTLO:    mn = MN_MTLO;
            FN_MULT:    mn = MN_MULT;
            FN_MULTU:   mn = MN_MULTU;
            FN_NOR:     mn = MN_NOR;
            FN_OR:      mn = MN_OR;
            FN_SLL:     mn = MN_SLL;
            FN_SLLV:    mn = MN_SLLV;
            FN_SLT:     mn = MN_SLT;
            FN_SLTU:    mn = MN_SLTU;
            FN_SRA:     mn = MN_SRA;
            FN_SRAV:    mn = MN_SRAV;
            FN_SRL:     mn = MN_SRL;
            FN_SRLV:    mn = MN_SRLV;
            FN_SUB:     mn = MN_SUB;
            FN_SUBU:    mn = MN_SUBU;
            FN_SYSCALL: mn = MN_SYSCALL;
            FN_XOR:     mn = MN_XOR;
            default:    mn = MN_UNKNOWN;
        endcase
        return mn;
    endfunction

    function automatic mnem_t decode_mnem(input field6_t op, input field6_t fn);
        mnem_t mn;
        unique case (op)
            OP_SPECIAL: mn = special_mnem(fn);
            OP_J:       mn = MN_J;
            OP_JAL:     mn = MN_JAL;
            OP_ADDI:    mn = MN_ADDI;
            OP_ADDIU:   mn = MN_ADDIU;
            OP_ANDI:    mn = MN_ANDI;
            OP_BEQ:     mn = MN_BEQ;
            OP_BNE:     mn = MN_BNE;
            OP_LB:      mn = MN_LB;
            OP_LBU:     mn = MN_LBU;
            OP_LH:      mn = MN_LH;
            OP_LHU:     mn = MN_LHU;
            OP_LUI:     mn = MN_LUI;
            OP_LW:      mn = MN_LW;
            OP_ORI:     mn = MN_ORI;
            OP_SB:      mn = MN_SB;
            OP_SLTI:    mn = MN_SLTI;
            OP_SLTIU:   mn = MN_SLTIU;
            OP_SH:      mn = MN_SH;
            OP_SW:      mn = MN_SW;
            OP_XORI:    mn = MN_XORI;
            default:    mn = MN_UNKNOWN;
        endcase
        return mn;
    endfunction

endpackage

/* rtl/mbsd_gather.sv */
module mbsd_gather (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mbsd_pkg::BYTE_W-1:0]   in_byte,
    output logic                          word_valid,
    input  logic                          word_ready,
    output mbsd_pkg::word_item_t          word_item
);
    import mbsd_pkg::*;

    logic [1:0]        pos_reg,   pos_next;
    logic [PART_W-1:0] part_reg,  part_next;
    logic [WORD_W-1:0] cnt_reg,   cnt_next;
    logic              valid_reg, valid_next;
    word_item_t        item_reg,  item_next;
    logic              in_fire;

    // The word register can take a new word when empty or draining this cycle.
    assign in_ready = !valid_reg || word_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb begin
        pos_next   = pos_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !word_ready;
        item_next  = item_reg;
        if (in_fire) begin
            if (pos_reg == LAST_BYTE_POS) begin
                item_next.number = cnt_reg;
                item_next.word   = {part_reg, in_byte};
                valid_next       = 1'b1;
                cnt_next         = cnt_reg + 1'b1;
                part_next        = '0;
                pos_next         = '0;
            end else begin
                part_next = {part_reg[PART_W-BYTE_W-1:0], in_byte};
                pos_next  = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            part_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            part_reg  <= part_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign word_valid = valid_reg;
    assign word_item  = item_reg;

endmodule

/* rtl/mbsd_decode.sv */
module mbsd_decode (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               word_valid,
    output logic                               word_ready,
    input  mbsd_pkg::word_item_t               word_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mbsd_pkg::OUT_TDATA_W-1:0]   out_data
);
    import mbsd_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg,  data_next;
    logic [WORD_W-1:0]      w;
    mnem_t                  mn;

    assign word_ready = !valid_reg || out_ready;
    assign w          = word_item.word;
    assign mn         = decode_mnem(w[31:26], w[5:0]);

    always_comb begin
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        if (word_valid && word_ready) begin
            valid_next = 1'b1;
            data_next  = {{OUT_PAD_W{1'b0}},
                          w[TARGET_W-1:0],
                          w[IMM_W-1:0],
                          w[10:6],
                          w[15:11],
                          w[20:16],
                          w[25:21],
                          mn,
                          w,
                          word_item.number};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/mips_byte_stream_decoder_core.sv */
// A full word goes into the word register, then its item into the output register.
// Throughput: one byte per cycle unless m_axis stalls; one item per four bytes accepted.
// The word register and the output register each refill in the cycle they drain.
// Reset (aresetn low, synchronous) empties both registers, drops a partial word
// and clears the word count.
module mips_byte_stream_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] data_byte
    input  logic [mbsd_pkg::BYTE_W-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] inst_number, [63:32] inst_word, [69:64] mnemonic, [74:70] src_reg,
    // [79:75] tgt_reg, [84:80] dst_reg, [89:85] shift_amount, [105:90] imm_value,
    // [131:106] jump_target, [135:132] zero
    output logic [mbsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import mbsd_pkg::*;

    logic       word_valid;
    logic       word_ready;
    word_item_t word_item;

    mbsd_gather u_gather (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_item  (word_item)
    );

    mbsd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_item  (word_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_word_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        word_valid && !word_ready |=> word_valid && $stable(word_item))
        else $error("word register changed while stalled");

    a_word_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        word_valid && word_ready |=>
            m_axis_tvalid && m_axis_tdata[2*WORD_W-1:WORD_W] == $past(word_item.word)
            && m_axis_tdata[WORD_W-1:0] == $past(word_item.number))
        else $error("decoded item does not match transferred word");

    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !word_valid |=> !m_axis_tvalid)
        else $error("output item repeated");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !word_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule
